/* hdl/sliding_window_fft16_unit_macros.svh */
// Assertion macros shared by the sliding-window FFT design.
`ifndef SLIDING_WINDOW_FFT16_UNIT_MACROS_SVH
`define SLIDING_WINDOW_FFT16_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SW16_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SW16_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sw16_pkg.sv */
package sw16_pkg;

  localparam int NPTS    = 16;
  localparam int RADIX   = 4;
  localparam int QSHIFT  = 15;
  localparam int WORD_W  = 16;
  localparam int BIN_W   = 4;
  localparam int GROUP_W = 2;
  localparam int NTW     = 10;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t vec_t [NPTS];
  typedef word_t col_t [RADIX];
  typedef logic [BIN_W-1:0] bin_t;

  localparam bin_t LAST_BIN = bin_t'(NPTS - 1);

  // Second-stage butterfly outputs, selected by bin[3:2].
  typedef enum logic [GROUP_W-1:0] {
    GRP_Q0 = 2'd0,
    GRP_Q1 = 2'd1,
    GRP_Q2 = 2'd2,
    GRP_Q3 = 2'd3
  } group_t;

  // Q15 twiddles W16^e; e = 0 and e = 4 bypass the multipliers.
  localparam word_t TW_RE [NTW] = '{
    16'sd32767, 16'sd30274, 16'sd23170, 16'sd12540, 16'sd0,
    16'sd0, -16'sd23170, 16'sd0, 16'sd0, -16'sd30274
  };
  localparam word_t TW_IM [NTW] = '{
    16'sd0, -16'sd12540, -16'sd23170, -16'sd30274, 16'sd0,
    16'sd0, -16'sd23170, 16'sd0, 16'sd0, 16'sd12540
  };

  localparam int TW_BYPASS = 0;
  localparam int TW_NEG_J  = 4;

  typedef struct packed {
    logic load;
    logic rotate;
  } tw_ctrl_t;

endpackage

/* hdl/sw16_ifs.sv */
interface sw16_in_if import sw16_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sw16_out_if import sw16_pkg::*; ();
  logic  valid;
  logic  ready;
  bin_t  bin_index;
  word_t real_part;
  word_t imag_part;
  logic  last_bin;

  modport source (output valid, output bin_index, output real_part,
                  output imag_part, output last_bin, input ready);
  modport sink (input valid, input bin_index, input real_part,
                input imag_part, input last_bin, output ready);
endinterface

/* hdl/sliding_window_fft16_unit.sv */
// Sliding-window 16-point FFT.
// samples: one signed 16-bit word per item, shifted into a 16-deep window
//   (newest at index 0); the spectrum of the updated window follows.
// spectrum: 16 words per sample, bins 0 to 15 in order, real and imaginary
//   parts wrapped to 16 bits, last_bin high on bin 15.
// Each sample passes the input, twiddle and output registers before bin 0 is
//   valid; bins then follow one per cycle while the receiver keeps ready high.
// The sample rate is set by the single output port that carries one bin
//   per cycle. The next sample is taken and its first-stage butterflies
//   registered while the bins of the previous one still drain.
// Stages: window and first radix-4 butterflies, then twiddle products into
//   a column-rotating register, then one second-stage output per cycle, while
//   the output is free, into the output register.
// Reset clears the window to zero and empties every stage.
// A stall on spectrum holds the output word and freezes the bin stream; the
//   input stage fills and then ready drops until the stream moves again.
`include "sliding_window_fft16_unit_macros.svh"

module sliding_window_fft16_unit import sw16_pkg::*; (
  input logic        clk,
  input logic        rst,
  sw16_in_if.sink    samples,
  sw16_out_if.source spectrum
);

  vec_t     b_re, b_im;
  col_t     col_re, col_im;
  tw_ctrl_t tw_ctrl;

  logic b_valid;
  logic c_valid;
  logic out_valid;
  bin_t bin;

  logic in_fire, out_free, c_adv, c_done, c_free, b_move;

  assign out_free = !out_valid || spectrum.ready;
  assign c_adv    = c_valid && out_free;
  assign c_done   = c_adv && (bin == LAST_BIN);
  assign c_free   = !c_valid || c_done;
  assign b_move   = b_valid && c_free;

  assign samples.ready = !b_valid || c_free;
  assign in_fire       = samples.valid && samples.ready;

  assign tw_ctrl.load   = b_move;
  assign tw_ctrl.rotate = c_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
      bin       <= '0;
    end else begin
      // Input stage: fill on intake, drop when handed on.
      if (in_fire) begin
        b_valid <= 1'b1;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end
      // Twiddle stage: hold the item for all 16 bins.
      if (b_move) begin
        c_valid <= 1'b1;
      end else if (c_done) begin
        c_valid <= 1'b0;
      end
      // Advance the bin counter; it wraps to zero after bin 15.
      if (c_adv) begin
        bin <= bin + 1'b1;
      end
      if (c_adv) begin
        out_valid <= 1'b1;
      end else if (spectrum.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  sw16_front u_front (
    .clk    (clk),
    .rst    (rst),
    .load   (in_fire),
    .sample (samples.sample),
    .b_re   (b_re),
    .b_im   (b_im)
  );

  sw16_twiddle u_twiddle (
    .clk    (clk),
    .ctrl   (tw_ctrl),
    .b_re   (b_re),
    .b_im   (b_im),
    .col_re (col_re),
    .col_im (col_im)
  );

  sw16_combine u_combine (
    .clk       (clk),
    .load      (c_adv),
    .bin       (bin),
    .col_re    (col_re),
    .col_im    (col_im),
    .bin_index (spectrum.bin_index),
    .real_part (spectrum.real_part),
    .imag_part (spectrum.imag_part),
    .last_bin  (spectrum.last_bin)
  );

  assign spectrum.valid = out_valid;

  `SW16_ASSERT_NEXT(a_intake_fills, clk, rst, in_fire, b_valid, "intake lost")
  `SW16_ASSERT_NEXT(a_hold_pending, clk, rst, b_valid && !c_free, b_valid, "pending item dropped")
  `SW16_ASSERT_NEXT(a_stream_whole, clk, rst, c_adv && (bin != LAST_BIN), c_valid, "bin stream cut short")
  `SW16_ASSERT_NEXT(a_emit_shows, clk, rst, c_adv, out_valid, "emitted bin not shown")
  `SW16_ASSERT_NOW(a_idle_counter, clk, rst, !c_valid, bin == '0, "bin counter off with no item")

endmodule

/* hdl/sw16_front.sv */
module sw16_front import sw16_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  word_t sample,
  output vec_t  b_re,
  output vec_t  b_im
);

  vec_t window;
  vec_t window_next;

  always_comb begin
    window_next[0] = sample;
    for (int n = 1; n < NPTS; n++) begin
      window_next[n] = window[n-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NPTS; n++) begin
        window[n] <= '0;
      end
    end else if (load) begin
      window <= window_next;
    end
  end

  // First radix-4 stage over entries i, i+4, i+8, i+12 of the shifted window.
  for (genvar gi = 0; gi < RADIX; gi++) begin : g_bfly
    word_t a0, a1, a2, a3;
    assign a0 = window_next[gi];
    assign a1 = window_next[gi + RADIX];
    assign a2 = window_next[gi + 2*RADIX];
    assign a3 = window_next[gi + 3*RADIX];

    always_ff @(posedge clk) begin
      if (load) begin
        b_re[RADIX*gi + 0] <= a0 + a1 + a2 + a3;
        b_im[RADIX*gi + 0] <= '0;
        b_re[RADIX*gi + 1] <= a0 - a2;
        b_im[RADIX*gi + 1] <= a3 - a1;
        b_re[RADIX*gi + 2] <= a0 - a1 + a2 - a3;
        b_im[RADIX*gi + 2] <= '0;
        b_re[RADIX*gi + 3] <= a0 - a2;
        b_im[RADIX*gi + 3] <= a1 - a3;
      end
    end
  end

endmodule

/* hdl/sw16_twiddle.sv */
module sw16_twiddle import sw16_pkg::*; (
  input  logic     clk,
  input  tw_ctrl_t ctrl,
  input  vec_t     b_re,
  input  vec_t     b_im,
  output col_t     col_re,
  output col_t     col_im
);

  // Stored by column k, row i (element 4*i + k).
  word_t c_re [RADIX][RADIX];
  word_t c_im [RADIX][RADIX];

  for (genvar gi = 0; gi < RADIX; gi++) begin : g_row
    for (genvar gk = 0; gk < RADIX; gk++) begin : g_col
      localparam int IDX = RADIX*gi + gk;
      localparam int E   = gi*gk;
      word_t tr, ti;

      if (E == TW_BYPASS) begin : g_pass
        assign tr = b_re[IDX];
        assign ti = b_im[IDX];
      end else if (E == TW_NEG_J) begin : g_negj
        assign tr = -b_im[IDX];
        assign ti = -b_re[IDX];
      end else begin : g_mul
        logic signed [2*WORD_W:0] acc_re, acc_im;
        assign acc_re = TW_RE[E] * b_re[IDX] - TW_IM[E] * b_im[IDX];
        assign acc_im = TW_RE[E] * b_im[IDX] + TW_IM[E] * b_re[IDX];
        // Floor by arithmetic shift, keep 16 bits.
        assign tr = acc_re[QSHIFT + WORD_W - 1:QSHIFT];
        assign ti = acc_im[QSHIFT + WORD_W - 1:QSHIFT];
      end

      always_ff @(posedge clk) begin
        if (ctrl.load) begin
          c_re[gk][gi] <= tr;
          c_im[gk][gi] <= ti;
        end else if (ctrl.rotate) begin
          c_re[gk][gi] <= c_re[(gk + 1) % RADIX][gi];
          c_im[gk][gi] <= c_im[(gk + 1) % RADIX][gi];
        end
      end
    end
  end

  for (genvar gr = 0; gr < RADIX; gr++) begin : g_tap
    assign col_re[gr] = c_re[0][gr];
    assign col_im[gr] = c_im[0][gr];
  end

endmodule

/* hdl/sw16_combine.sv */
module sw16_combine import sw16_pkg::*; (
  input  logic  clk,
  input  logic  load,
  input  bin_t  bin,
  input  col_t  col_re,
  input  col_t  col_im,
  output bin_t  bin_index,
  output word_t real_part,
  output word_t imag_part,
  output logic  last_bin
);

  word_t  xr, xi;
  group_t grp;

  assign grp = group_t'(bin[BIN_W-1:BIN_W-GROUP_W]);

  // Second radix-4 stage, one butterfly output per cycle while load is high.
  always_comb begin
    case (grp)
      GRP_Q0: begin
        xr = col_re[0] + col_re[1] + col_re[2] + col_re[3];
        xi = col_im[0] + col_im[1] + col_im[2] + col_im[3];
      end
      GRP_Q1: begin
        xr = col_re[0] + col_im[1] - col_re[2] - col_im[3];
        xi = col_im[0] - col_re[1] - col_im[2] + col_re[3];
      end
      GRP_Q2: begin
        xr = col_re[0] - col_re[1] + col_re[2] - col_re[3];
        xi = col_im[0] - col_im[1] + col_im[2] - col_im[3];
      end
      GRP_Q3: begin
        xr = col_re[0] - col_im[1] - col_re[2] + col_im[3];
        xi = col_im[0] + col_re[1] - col_im[2] - col_re[3];
      end
      default: begin
        xr = '0;
        xi = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin_index <= bin;
      real_part <= xr;
      imag_part <= xi;
      last_bin  <= (bin == LAST_BIN);
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the sliding-window 16-point FFT.
// Every sample that the block takes is shifted into a local copy of the
// window. The 16 bins of that window are computed here and queued. Each bin
// word that leaves the block is checked against the oldest queued bin.
module tb_top import sw16_pkg::*; ();

  // Q15 rotation factors W16^e, indexed by the exponent i*k.
  localparam int ROT_RE [10] = '{32767, 30274, 23170, 12540, 0, 0, -23170, 0, 0, -30274};
  localparam int ROT_IM [10] = '{0, -12540, -23170, -30274, 0, 0, -23170, 0, 0, 12540};
  // Exponent zero passes straight through. Exponent four is -j: swap the parts and negate.
  localparam int EXP_UNITY = 0;
  localparam int EXP_NEG_J = 4;

  localparam int RANDOM_WORDS  = 450;
  localparam int IDLE_PCT      = 12;
  localparam int QUIET_FROM    = 150;   // no idling on either side for these samples
  localparam int QUIET_TO      = 260;
  localparam int HOLD_AT       = 60;    // receiver holds off once this many samples are in
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_AT      = 320;   // random word that waits for an empty bin queue
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
  localparam int REPORT_CAP    = 100;

  typedef struct {
    bin_t  bin;
    word_t re;
    word_t im;
    logic  last;
  } bin_word_t;

  typedef struct {
    word_t value;
    bit    wait_drain;
  } feed_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sw16_in_if  sample_bus ();
  sw16_out_if bin_bus ();

  sliding_window_fft16_unit dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (sample_bus),
    .spectrum (bin_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the window: newest sample at index 0, zero after reset.
  int         window_copy [NPTS];
  bin_word_t  bins_due [$];
  feed_word_t feed_q [$];

  int  samples_in;
  int  bins_out;
  int  in_stalls;
  int  errors;
  int  hold_left;
  bit  hold_done;
  bit  in_taken;
  bit  run_done;

  function automatic int wrap16(int v);
    word_t t;
    t = word_t'(v);
    return int'(t);
  endfunction

  // Floor the Q15 product: an arithmetic shift right by 15, then wrap.
  function automatic int q15(int v);
    return wrap16(v >>> QSHIFT);
  endfunction

  // Shift the new sample into the window and queue the 16 bins it produces.
  function automatic void queue_spectrum(word_t smp);
    int br [NPTS];
    int bi [NPTS];
    int cr [NPTS];
    int ci [NPTS];
    int xr [NPTS];
    int xi [NPTS];
    int a0, a1, a2, a3, e, idx;
    int r0, r1, r2, r3, m0, m1, m2, m3;
    bin_word_t w;
    for (int n = NPTS - 1; n > 0; n--) window_copy[n] = window_copy[n - 1];
    window_copy[0] = int'(smp);

    // First stage: radix-4 butterflies over entries i, i+4, i+8, i+12.
    for (int i = 0; i < RADIX; i++) begin
      a0 = window_copy[i];
      a1 = window_copy[i + 4];
      a2 = window_copy[i + 8];
      a3 = window_copy[i + 12];
      br[4*i]     = wrap16(a0 + a1 + a2 + a3);
      bi[4*i]     = 0;
      br[4*i + 1] = wrap16(a0 - a2);
      bi[4*i + 1] = wrap16(a3 - a1);
      br[4*i + 2] = wrap16(a0 - a1 + a2 - a3);
      bi[4*i + 2] = 0;
      br[4*i + 3] = wrap16(a0 - a2);
      bi[4*i + 3] = wrap16(a1 - a3);
    end

    // Rotate by W16^(i*k).
    for (int i = 0; i < RADIX; i++) begin
      for (int k = 0; k < RADIX; k++) begin
        idx = 4*i + k;
        e = i * k;
        if (e == EXP_UNITY) begin
          cr[idx] = br[idx];
          ci[idx] = bi[idx];
        end else if (e == EXP_NEG_J) begin
          cr[idx] = wrap16(-bi[idx]);
          ci[idx] = wrap16(-br[idx]);
        end else begin
          cr[idx] = q15(ROT_RE[e] * br[idx] - ROT_IM[e] * bi[idx]);
          ci[idx] = q15(ROT_RE[e] * bi[idx] + ROT_IM[e] * br[idx]);
        end
      end
    end

    // Second stage: radix-4 butterflies across the rotated columns.
    for (int k = 0; k < RADIX; k++) begin
      r0 = cr[k]; r1 = cr[k + 4]; r2 = cr[k + 8]; r3 = cr[k + 12];
      m0 = ci[k]; m1 = ci[k + 4]; m2 = ci[k + 8]; m3 = ci[k + 12];
      xr[k]      = wrap16(r0 + r1 + r2 + r3);
      xi[k]      = wrap16(m0 + m1 + m2 + m3);
      xr[k + 4]  = wrap16(r0 + m1 - r2 - m3);
      xi[k + 4]  = wrap16(m0 - r1 - m2 + r3);
      xr[k + 8]  = wrap16(r0 - r1 + r2 - r3);
      xi[k + 8]  = wrap16(m0 - m1 + m2 - m3);
      xr[k + 12] = wrap16(r0 - m1 - r2 + m3);
      xi[k + 12] = wrap16(m0 + r1 - m2 - r3);
    end

    for (int k = 0; k < NPTS; k++) begin
      w.bin  = bin_t'(k);
      w.re   = word_t'(xr[k]);
      w.im   = word_t'(xi[k]);
      w.last = (bin_t'(k) == LAST_BIN);
      bins_due.push_back(w);
    end
  endfunction

  // Mix of full-range noise, small values, rail values and near-rail values.
  function automatic word_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return word_t'($urandom);
    if (sel < 60) return word_t'(int'($urandom_range(511)) - 256);
    if (sel < 80) begin
      case ($urandom_range(4))
        0: return word_t'(32767);
        1: return word_t'(-32768);
        2: return word_t'(-1);
        3: return word_t'(1);
        default: return word_t'(0);
      endcase
    end
    if ($urandom_range(1) != 0) return word_t'(32767 - int'($urandom_range(255)));
    return word_t'(-32768 + int'($urandom_range(255)));
  endfunction

  function automatic bit quiet_window();
    return samples_in >= QUIET_FROM && samples_in < QUIET_TO;
  endfunction

  // Driver: present words at the falling edge. Hold a word until it has
  // been taken, then advance to the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      sample_bus.valid  <= 1'b0;
      sample_bus.sample <= '0;
    end else if (sample_bus.valid && !in_taken) begin
      // hold the word on offer
    end else if (feed_q.size() == 0) begin
      sample_bus.valid <= 1'b0;
    end else if (feed_q[0].wait_drain && bins_due.size() != 0) begin
      // pause until every queued bin has come out
      sample_bus.valid <= 1'b0;
    end else if (hold_left == 0 && !quiet_window() && $urandom_range(99) < IDLE_PCT) begin
      sample_bus.valid <= 1'b0;
    end else begin
      sample_bus.valid  <= 1'b1;
      sample_bus.sample <= feed_q[0].value;
      feed_q.pop_front();
    end
  end

  // Receiver: random back-pressure, plus one long hold-off that lets the
  // block fill up and drop its input ready while samples keep coming.
  always @(negedge clk) begin
    if (rst) begin
      bin_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      bin_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && samples_in >= HOLD_AT) begin
      bin_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      bin_bus.ready <= quiet_window() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: check bin words first, then queue the spectrum of a taken
  // sample. A sample's own bins never leave on the edge that takes it.
  always @(posedge clk) begin
    bin_word_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (bin_bus.valid && bin_bus.ready) begin
        bins_out++;
        if (bins_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: unexpected bin word: bin %0d re %0d im %0d last %0b", $time,
                     bin_bus.bin_index, bin_bus.real_part, bin_bus.imag_part,
                     bin_bus.last_bin);
        end else begin
          want = bins_due.pop_front();
          if (bin_bus.bin_index !== want.bin || bin_bus.real_part !== want.re ||
              bin_bus.imag_part !== want.im || bin_bus.last_bin !== want.last) begin
            errors++;
            if (errors <= REPORT_CAP)
              $display("%0t: bin mismatch: expected bin %0d re %0d im %0d last %0b, got bin %0d re %0d im %0d last %0b",
                       $time, want.bin, want.re, want.im, want.last,
                       bin_bus.bin_index, bin_bus.real_part, bin_bus.imag_part,
                       bin_bus.last_bin);
          end
        end
      end
      if (sample_bus.valid && sample_bus.ready) begin
        samples_in++;
        queue_spectrum(sample_bus.sample);
      end
      if (sample_bus.valid && !sample_bus.ready) in_stalls++;
      in_taken <= sample_bus.valid && sample_bus.ready;
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || run_done || (sample_bus.valid && sample_bus.ready) ||
        (bin_bus.valid && bin_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d bins outstanding", $time,
                 STALL_LIMIT, bins_due.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic add_word(word_t v, bit wait_drain);
    feed_word_t f;
    f.value      = v;
    f.wait_drain = wait_drain;
    feed_q.push_back(f);
  endtask

  initial begin
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    bin_bus.ready     = 1'b0;
    samples_in = 0;
    bins_out   = 0;
    in_stalls  = 0;
    errors     = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    in_taken   = 1'b0;
    run_done   = 1'b0;
    foreach (window_copy[n]) window_copy[n] = 0;

    // Directed: a unit impulse, full-scale DC that overflows the sums,
    // alternating rails for the Nyquist bin, and bit patterns.
    add_word(word_t'(1), 1'b0);
    add_word(word_t'(0), 1'b0);
    repeat (4) add_word(word_t'(32767), 1'b0);
    repeat (4) add_word(word_t'(-32768), 1'b0);
    repeat (3) begin
      add_word(word_t'(32767), 1'b0);
      add_word(word_t'(-32768), 1'b0);
    end
    add_word(word_t'(-1), 1'b0);
    add_word(word_t'(16'h5555), 1'b0);
    add_word(word_t'(16'hAAAA), 1'b0);
    add_word(word_t'(0), 1'b0);

    // Random part; the first word and one later word wait for the bin queue to drain first.
    for (int n = 0; n < RANDOM_WORDS; n++)
      add_word(pick_sample(), n == 0 || n == DRAIN_AT);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (feed_q.size() != 0 || sample_bus.valid || bins_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    run_done = 1'b1;

    $display("run covered %0d samples and %0d bin words, input stalled %0d cycles",
             samples_in, bins_out, in_stalls);
    $display("%0d mismatches, %0d bins left unmatched", errors, bins_due.size());
    if (errors == 0 && bins_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/sw16_pkg.sv
hdl/sw16_ifs.sv
hdl/sw16_front.sv
hdl/sw16_twiddle.sv
hdl/sw16_combine.sv
hdl/sliding_window_fft16_unit.sv
sim/tb_top.sv
